FILE: rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants and types of the 3D point-in-triangle test: default
// widths, tolerance register layout and configuration register indexes.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;

  // Tolerance registers
  localparam int TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] PLANE_TOL_RST = TOL_WIDTH'(4);
  localparam logic [TOL_WIDTH-1:0] ZERO_TOL_RST  = TOL_WIDTH'(4);

  // Configuration register indexes
  localparam int CFG_IDX_WIDTH = 1;
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_PLANE_TOL = 1'b0,
    CFG_ZERO_TOL  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [TOL_WIDTH-1:0] plane_tol;
    logic [TOL_WIDTH-1:0] zero_tol;
  } tol_cfg_t;

endpackage

FILE: rtl/pit_wmul.sv
// ----------------------------------------------------------------------------
// pit_wmul
// Two-stage signed multiplier for wide operands: four half-width partial
// products in the first stage, shifted sum in the second.
// ----------------------------------------------------------------------------
module pit_wmul #(
  parameter int AW = 52
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [AW-1:0]   b_i,
  output logic signed [2*AW-1:0] p_o
);

  localparam int H  = AW / 2;
  localparam int HW = AW - H;
  localparam int PW = 2 * AW;

  logic signed [HW-1:0]   ah, bh;
  logic        [H-1:0]    al, bl;
  logic signed [2*HW-1:0] hh_q;
  logic signed [HW+H:0]   hl_q, lh_q;
  logic        [2*H-1:0]  ll_q;
  logic signed [PW-1:0]   hh_x, hl_x, lh_x, ll_x, p_d, p_q;

  // Split operands into signed high and unsigned low halves
  assign ah = a_i[AW-1:H];
  assign bh = b_i[AW-1:H];
  assign al = a_i[H-1:0];
  assign bl = b_i[H-1:0];

  // Form partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= ah * bh;
      hl_q <= ah * $signed({1'b0, bl});
      lh_q <= $signed({1'b0, al}) * bh;
      ll_q <= al * bl;
    end
  end

  // Combine partial products
  always_comb begin
    hh_x = PW'(hh_q);
    hl_x = PW'(hl_q);
    lh_x = PW'(lh_q);
    ll_x = $signed(PW'(ll_q));
    p_d  = (hh_x <<< (2 * H)) + ((hl_x + lh_x) <<< H) + ll_x;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/pit_front.sv
// ----------------------------------------------------------------------------
// pit_front
// Front end of the test: edge vectors, dot products, determinant and the
// two barycentric numerators, over six register stages.
// ----------------------------------------------------------------------------
module pit_front #(
  parameter  int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF,
  localparam int VW          = COORD_WIDTH + 1,
  localparam int PRW         = 2 * VW,
  localparam int DW          = PRW + 2,
  localparam int PW          = 2 * DW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [2:0][COORD_WIDTH-1:0]  a_i,
  input  logic [2:0][COORD_WIDTH-1:0]  b_i,
  input  logic [2:0][COORD_WIDTH-1:0]  c_i,
  input  logic [2:0][COORD_WIDTH-1:0]  p_i,
  output logic                         valid_o,
  output logic [9*VW-1:0]              vec_o,
  output logic signed [PW-1:0]         det_o,
  output logic signed [PW-1:0]         nu_o,
  output logic signed [PW-1:0]         nv_o
);

  localparam int NST = 6;
  // Operand pairs of the determinant and numerator products
  localparam int MA [6] = '{0, 1, 3, 1, 0, 1};
  localparam int MB [6] = '{3, 1, 2, 4, 4, 2};

  logic [NST:1]            vld_q;
  logic [8:0][VW-1:0]      vec_d;
  logic [8:0][VW-1:0]      vec_q [NST];
  logic signed [PRW-1:0]   pr_d [15];
  logic signed [PRW-1:0]   pr_q [15];
  logic signed [DW-1:0]    dot_d [5];
  logic signed [DW-1:0]    dot_q [5];
  logic signed [2*DW-1:0]  mp [6];
  logic signed [PW-1:0]    det_d, nu_d, nv_d, det_q, nu_q, nv_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-1:1], valid_i};
    end
  end

  // Edge vectors: v0 = C-A, v1 = B-A, v2 = P-A
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_d[k]     = VW'($signed(c_i[k])) - VW'($signed(a_i[k]));
      vec_d[3 + k] = VW'($signed(b_i[k])) - VW'($signed(a_i[k]));
      vec_d[6 + k] = VW'($signed(p_i[k])) - VW'($signed(a_i[k]));
    end
  end

  // Carry edge vectors along the stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q[0] <= vec_d;
      for (int s = 1; s < NST; s++) begin
        vec_q[s] <= vec_q[s-1];
      end
    end
  end

  // Element products for d00, d01, d02, d11, d12
  always_comb begin
    for (int t = 0; t < 5; t++) begin
      for (int k = 0; k < 3; k++) begin
        pr_d[3*t + k] = $signed(vec_q[0][3*((t < 3) ? 0 : 1) + k])
                      * $signed(vec_q[0][3*((t < 3) ? t : t - 2) + k]);
      end
    end
  end

  // Sum element products into dot products
  always_comb begin
    for (int t = 0; t < 5; t++) begin
      dot_d[t] = DW'(pr_q[3*t]) + DW'(pr_q[3*t + 1]) + DW'(pr_q[3*t + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q  <= pr_d;
      dot_q <= dot_d;
    end
  end

  // Wide products of dot products
  for (genvar g = 0; g < 6; g++) begin : g_mul
    pit_wmul #(
      .AW (DW)
    ) u_wmul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (dot_q[MA[g]]),
      .b_i   (dot_q[MB[g]]),
      .p_o   (mp[g])
    );
  end

  // Determinant and numerators
  always_comb begin
    det_d = PW'(mp[0]) - PW'(mp[1]);
    nu_d  = PW'(mp[2]) - PW'(mp[3]);
    nv_d  = PW'(mp[4]) - PW'(mp[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_d;
      nu_q  <= nu_d;
      nv_q  <= nv_d;
    end
  end

  assign valid_o = vld_q[NST];
  assign vec_o   = vec_q[NST-1];
  assign det_o   = det_q;
  assign nu_o    = nu_q;
  assign nv_o    = nv_q;

endmodule

FILE: rtl/pit_div.sv
// ----------------------------------------------------------------------------
// pit_div
// Pipelined restoring divider for both barycentric weights: one quotient
// bit per stage, with an overflow flag for weights out of the useful range.
// ----------------------------------------------------------------------------
module pit_div #(
  parameter  int PW = 105,
  parameter  int FB = 12,
  parameter  int QB = 18,
  parameter  int SW = 225,
  localparam int UW = QB + 1,
  localparam int RW = PW + QB + FB
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [PW-1:0] det_i,
  input  logic signed [PW-1:0] nu_i,
  input  logic signed [PW-1:0] nv_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [UW-1:0] u_o,
  output logic signed [UW-1:0] v_o,
  output logic                 u_big_o,
  output logic                 v_big_o,
  output logic                 degen_o,
  output logic [SW-1:0]        side_o
);

  logic [QB:0]       vld_q;
  logic [QB:0]       degen_q;
  logic [SW-1:0]     side_q [QB+1];
  logic [PW-1:0]     dm_q   [QB+1];
  logic [RW-1:0]     rem_q  [QB+1][2];
  logic [QB-1:0]     quo_q  [QB+1][2];
  logic [1:0]        neg_q  [QB+1];
  logic [1:0]        big_q  [QB+1];

  logic [PW-1:0]     nmag  [2];
  logic [RW-1:0]     num_w [2];
  logic [RW-1:0]     lim_w;
  logic [1:0]        neg_d, big_d;
  logic              degen_d;
  logic [UW-1:0]     mag_u, mag_v;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  // Take magnitudes, scale numerators, flag weights that overflow
  always_comb begin
    neg_d[0] = nu_i[PW-1];
    neg_d[1] = nv_i[PW-1];
    nmag[0]  = nu_i[PW-1] ? PW'(-nu_i) : PW'(nu_i);
    nmag[1]  = nv_i[PW-1] ? PW'(-nv_i) : PW'(nv_i);
    lim_w    = RW'($unsigned(det_i)) << QB;
    for (int l = 0; l < 2; l++) begin
      num_w[l] = RW'(nmag[l]) << FB;
      big_d[l] = num_w[l] >= lim_w;
    end
    degen_d = (det_i == '0) || det_i[PW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      degen_q[0] <= degen_d;
      side_q[0]  <= side_i;
      dm_q[0]    <= $unsigned(det_i);
      neg_q[0]   <= neg_d;
      big_q[0]   <= big_d;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= num_w[l];
        quo_q[0][l] <= '0;
      end
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int BI = QB - s;

    logic [RW-1:0] trial;
    logic [1:0]    take;
    logic [RW-1:0] rem_d [2];
    logic [QB-1:0] quo_d [2];

    always_comb begin
      trial = RW'(dm_q[s-1]) << BI;
      for (int l = 0; l < 2; l++) begin
        take[l]      = rem_q[s-1][l] >= trial;
        rem_d[l]     = take[l] ? rem_q[s-1][l] - trial : rem_q[s-1][l];
        quo_d[l]     = quo_q[s-1][l];
        quo_d[l][BI] = take[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]   <= rem_d;
        quo_q[s]   <= quo_d;
        degen_q[s] <= degen_q[s-1];
        side_q[s]  <= side_q[s-1];
        dm_q[s]    <= dm_q[s-1];
        neg_q[s]   <= neg_q[s-1];
        big_q[s]   <= big_q[s-1];
      end
    end
  end

  // Apply signs to the quotient magnitudes
  assign mag_u = {1'b0, quo_q[QB][0]};
  assign mag_v = {1'b0, quo_q[QB][1]};
  assign u_o   = neg_q[QB][0] ? -$signed(mag_u) : $signed(mag_u);
  assign v_o   = neg_q[QB][1] ? -$signed(mag_v) : $signed(mag_v);

  assign valid_o = vld_q[QB];
  assign u_big_o = big_q[QB][0];
  assign v_big_o = big_q[QB][1];
  assign degen_o = degen_q[QB];
  assign side_o  = side_q[QB];

`ifndef SYNTHESIS
  a_rem_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[QB] && !degen_q[QB] && !big_q[QB][0]) |-> (rem_q[QB][0] < RW'(dm_q[QB])))
    else $error("u remainder not below determinant");
  a_rem_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[QB] && !degen_q[QB] && !big_q[QB][1]) |-> (rem_q[QB][1] < RW'(dm_q[QB])))
    else $error("v remainder not below determinant");
  a_det_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !degen_q[0]) |-> (dm_q[0] != '0))
    else $error("zero divisor on a non-degenerate transaction");
`endif

endmodule

FILE: rtl/pit_back.sv
// ----------------------------------------------------------------------------
// pit_back
// Back end of the test: barycentric range checks, point rebuild and the
// squared distance compare against the plane tolerance, over four stages.
// ----------------------------------------------------------------------------
module pit_back #(
  parameter  int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF,
  parameter  int FRAC_BITS   = pit_pkg::FRAC_BITS_DEF,
  parameter  int QB          = 18,
  localparam int VW          = COORD_WIDTH + 1,
  localparam int UW          = QB + 1,
  localparam int MW          = UW + VW,
  localparam int AW          = MW + 2,
  localparam int CW          = UW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  pit_pkg::tol_cfg_t    cfg_i,
  input  logic signed [UW-1:0] u_i,
  input  logic signed [UW-1:0] v_i,
  input  logic                 u_big_i,
  input  logic                 v_big_i,
  input  logic                 degen_i,
  input  logic [9*VW-1:0]      vec_i,
  output logic                 valid_o,
  output logic                 inside_o,
  output logic                 degen_o
);

  import pit_pkg::*;

  localparam int TW  = TOL_WIDTH;
  localparam int SQW = 2 * TW + 2;

  logic [4:1]             vld_q;
  logic [8:0][VW-1:0]     vec;

  // Stage 1 signals
  logic signed [CW-1:0]   u_x, v_x, zt_n, one_x;
  logic                   bary_ok;
  logic signed [MW-1:0]   mu_d [3], mv_d [3], mu_q [3], mv_q [3];
  logic [VW-1:0]          v2_q [3];
  logic                   ok1_q, deg1_q;

  // Stage 2 signals
  logic signed [AW-1:0]   acc [3], off [3], dd [3], d2_q [3];
  logic                   ok2_q, deg2_q;

  // Stage 3 signals
  logic [AW-1:0]          ad [3];
  logic [2:0]             fail_d, fail3_q;
  logic [2*TW-1:0]        sq_d [3], sq3_q [3];
  logic                   ok3_q, deg3_q;

  // Stage 4 signals
  logic [SQW-1:0]         sq_sum;
  logic [2*TW-1:0]        tol_sq;
  logic                   inside_d, inside_q, deg4_q;

  assign vec = vec_i;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:1], valid_i};
    end
  end

  // Check barycentric ranges, scale edge vectors by the weights
  always_comb begin
    u_x     = CW'(u_i);
    v_x     = CW'(v_i);
    zt_n    = -$signed(CW'(cfg_i.zero_tol));
    one_x   = CW'(1) << FRAC_BITS;
    bary_ok = !degen_i && !u_big_i && !v_big_i && (u_x >= zt_n) && (v_x >= zt_n)
              && ((u_x + v_x) <= one_x);
    for (int k = 0; k < 3; k++) begin
      mu_d[k] = u_i * $signed(vec[k]);
      mv_d[k] = v_i * $signed(vec[3 + k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok1_q  <= bary_ok;
      deg1_q <= degen_i;
      mu_q   <= mu_d;
      mv_q   <= mv_d;
      for (int k = 0; k < 3; k++) begin
        v2_q[k] <= vec[6 + k];
      end
    end
  end

  // Rebuild offsets and differ them from P-A
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = AW'(mu_q[k]) + AW'(mv_q[k]);
      off[k] = acc[k] >>> FRAC_BITS;
      dd[k]  = AW'($signed(v2_q[k])) - off[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok2_q  <= ok1_q;
      deg2_q <= deg1_q;
      d2_q   <= dd;
    end
  end

  // Compare each distance with the tolerance and square it
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ad[k]     = d2_q[k][AW-1] ? AW'(-d2_q[k]) : AW'(d2_q[k]);
      fail_d[k] = ad[k] >= AW'(cfg_i.plane_tol);
      sq_d[k]   = ad[k][TW-1:0] * ad[k][TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok3_q   <= ok2_q;
      deg3_q  <= deg2_q;
      fail3_q <= fail_d;
      sq3_q   <= sq_d;
    end
  end

  // Compare the squared distance with the squared tolerance
  always_comb begin
    sq_sum   = SQW'(sq3_q[0]) + SQW'(sq3_q[1]) + SQW'(sq3_q[2]);
    tol_sq   = cfg_i.plane_tol * cfg_i.plane_tol;
    inside_d = ok3_q && !(|fail3_q) && (sq_sum < SQW'(tol_sq));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_d;
      deg4_q   <= deg3_q;
    end
  end

  assign valid_o  = vld_q[4];
  assign inside_o = inside_q;
  assign degen_o  = deg4_q;

endmodule

FILE: rtl/point_in_triangle_3d_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_3d_test
// Streaming barycentric point-in-triangle test in 3D, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: the
//   vertices A, B, C and the query point P. Output channel (out_valid_o /
//   out_stall_i) returns one transaction per input: inside_res_o and
//   degenerate_o. A transaction moves on an edge with valid high, stall low.
//   Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always
//   ready; index 0 is the plane tolerance, index 1 the zero tolerance. Write
//   them only while the pipeline is empty.
//   QB = max(FRAC_BITS, 16) + 2. The pipeline has six front stages
//   (differences, products, dot products, two wide multiply stages,
//   determinant), QB + 1 divider stages (an input stage, then one quotient
//   bit each) and four back stages.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   Reset empties the pipeline and sets both tolerances to 4.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_in_triangle_3d_test #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pit_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pit_pkg::CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  logic [pit_pkg::TOL_WIDTH-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_c_z_i,
  input  logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  logic signed [COORD_WIDTH-1:0]        point_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 inside_res_o,
  output logic                                 degenerate_o
);

  import pit_pkg::*;

  localparam int VW = COORD_WIDTH + 1;
  localparam int DW = 2 * VW + 2;
  localparam int PW = 2 * DW + 1;
  localparam int QB = ((FRAC_BITS > TOL_WIDTH) ? FRAC_BITS : TOL_WIDTH) + 2;
  localparam int UW = QB + 1;
  localparam int SW = 9 * VW;

  tol_cfg_t                    cfg_d, cfg_q;
  logic                        pipe_en;
  logic [2:0][COORD_WIDTH-1:0] pa, pb, pc, pp;

  logic                        f_valid;
  logic [SW-1:0]               f_vec;
  logic signed [PW-1:0]        f_det, f_nu, f_nv;

  logic                        d_valid, d_u_big, d_v_big, d_degen;
  logic signed [UW-1:0]        d_u, d_v;
  logic [SW-1:0]               d_vec;

  // Update tolerance registers on a write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PLANE_TOL: cfg_d.plane_tol = cfg_data_i;
        CFG_ZERO_TOL:  cfg_d.zero_tol  = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{plane_tol: PLANE_TOL_RST, zero_tol: ZERO_TOL_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Hold the whole pipeline while a result waits on a stalled receiver
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  // Group coordinates per point, x in element 0
  assign pa = {vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};
  assign pb = {vertex_b_z_i, vertex_b_y_i, vertex_b_x_i};
  assign pc = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i};
  assign pp = {point_z_i, point_y_i, point_x_i};

  pit_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .a_i     (pa),
    .b_i     (pb),
    .c_i     (pc),
    .p_i     (pp),
    .valid_o (f_valid),
    .vec_o   (f_vec),
    .det_o   (f_det),
    .nu_o    (f_nu),
    .nv_o    (f_nv)
  );

  pit_div #(
    .PW (PW),
    .FB (FRAC_BITS),
    .QB (QB),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (f_valid),
    .det_i   (f_det),
    .nu_i    (f_nu),
    .nv_i    (f_nv),
    .side_i  (f_vec),
    .valid_o (d_valid),
    .u_o     (d_u),
    .v_o     (d_v),
    .u_big_o (d_u_big),
    .v_big_o (d_v_big),
    .degen_o (d_degen),
    .side_o  (d_vec)
  );

  pit_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .QB          (QB)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (d_valid),
    .cfg_i    (cfg_q),
    .u_i      (d_u),
    .v_i      (d_v),
    .u_big_i  (d_u_big),
    .v_big_i  (d_v_big),
    .degen_i  (d_degen),
    .vec_i    (d_vec),
    .valid_o  (out_valid_o),
    .inside_o (inside_res_o),
    .degen_o  (degenerate_o)
  );

endmodule
